>>> rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// property holds at every edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

`endif

>>> rtl/shp_pkg.sv
package shp_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  byte_out;
        logic [3:0]  byte_role;
        logic [7:0]  address_index;
        logic [1:0]  verdict;
        logic [8:0]  header_length;
        logic [7:0]  address_type;
        logic [7:0]  address_length;
        logic [7:0]  code;
        logic [15:0] port;
    } t_out_item;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_BAD     = 2'd2
    } t_phase;

    localparam logic [1:0] FMT_REQUEST = 2'd0;
    localparam logic [1:0] FMT_REPLY   = 2'd1;
    localparam logic [1:0] FMT_UDP     = 2'd2;

    localparam logic [3:0] ROLE_FIXED   = 4'd0;
    localparam logic [3:0] ROLE_CODE    = 4'd1;
    localparam logic [3:0] ROLE_ATYP    = 4'd2;
    localparam logic [3:0] ROLE_DLEN    = 4'd3;
    localparam logic [3:0] ROLE_ADDR    = 4'd4;
    localparam logic [3:0] ROLE_PORT_HI = 4'd5;
    localparam logic [3:0] ROLE_PORT_LO = 4'd6;
    localparam logic [3:0] ROLE_PAYLOAD = 4'd7;
    localparam logic [3:0] ROLE_IGNORED = 4'd8;

    localparam logic [1:0] V_PROGRESS   = 2'd0;
    localparam logic [1:0] V_COMPLETE   = 2'd1;
    localparam logic [1:0] V_MALFORMED  = 2'd2;
    localparam logic [1:0] V_INCOMPLETE = 2'd3;

    localparam logic [7:0] SOCKS_VERSION = 8'h05;
    localparam logic [7:0] ATYP_IPV4     = 8'd1;
    localparam logic [7:0] ATYP_DOMAIN   = 8'd3;
    localparam logic [7:0] ATYP_IPV6     = 8'd4;
    localparam logic [7:0] LEN_IPV4      = 8'd4;
    localparam logic [7:0] LEN_IPV6      = 8'd16;

    localparam logic [8:0] POS_ATYP      = 9'd3;
    localparam logic [8:0] POS_DLEN      = 9'd4;
    localparam logic [8:0] POS_CODE      = 9'd1;
    localparam logic [8:0] POS_VERSION   = 9'd0;
    localparam logic [8:0] POS_FRAG      = 9'd2;
    localparam logic [8:0] POS_MAX       = 9'd262;

endpackage

>>> rtl/socks5_header_parser.sv
// SOCKS5 header parser: takes one byte per item and returns one result item per byte, labeling
// the byte's role (request, reply or UDP datagram header, chosen by the format register) with
// the header verdict, address info and port. One byte can be accepted every cycle while the
// output is not stalled; a byte passes the input register, then the result register, before
// its result is offered, and a stall on the output side backs up through those two registers
// only. The user must write the format register through i_cfg_we/i_cfg_data only while no
// byte is in flight; the block itself does not enforce this. A byte with end_of_buffer set
// restarts the parser after its own result.
`include "assert_macros.svh"

module socks5_header_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  shp_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output shp_pkg::t_out_item o_out_item
);
    import shp_pkg::*;

    logic [1:0] r_format;
    logic       r_in_valid;
    t_in_item   r_in_item;
    logic       r_out_valid;
    t_out_item  r_out_item;
    t_out_item  result;
    logic       advance;
    logic       in_accept;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_accept  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= FMT_REQUEST;
        end else if (i_cfg_we) begin
            r_format <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_item <= i_in_item;
        end
    end

    shp_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_format (r_format),
        .i_item   (r_in_item),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `ASSERT_IMPL(a_stall_means_full, i_clk, i_rst_n, !o_in_ready, r_in_valid && r_out_valid)
    `ASSERT_NEXT(a_advance_fills_out, i_clk, i_rst_n, advance, r_out_valid)

endmodule

>>> rtl/shp_parse.sv
`include "assert_macros.svh"

module shp_parse (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic [1:0]         i_format,
    input  shp_pkg::t_in_item  i_item,
    output shp_pkg::t_out_item o_result
);
    import shp_pkg::*;

    logic [8:0] r_pos, n_pos;
    logic [7:0] r_atyp, n_atyp;
    logic [7:0] r_alen, n_alen;
    logic [7:0] r_code, n_code;
    logic [7:0] r_port_hi, n_port_hi;
    t_phase     r_phase, n_phase;
    logic       r_bad, n_bad;

    logic       udp;
    logic [7:0] b;
    logic       eob;
    logic [8:0] addr_start;
    logic [8:0] rel;
    logic [8:0] alen_ext;

    assign udp        = (i_format == FMT_UDP);
    assign b          = i_item.data_byte;
    assign eob        = i_item.end_of_buffer;
    assign addr_start = (r_atyp == ATYP_DOMAIN) ? (POS_DLEN + 9'd1) : POS_DLEN;
    assign rel        = r_pos - addr_start;
    assign alen_ext   = {1'b0, r_alen};

    always_comb begin
        n_pos     = r_pos;
        n_atyp    = r_atyp;
        n_alen    = r_alen;
        n_code    = r_code;
        n_port_hi = r_port_hi;
        n_phase   = r_phase;
        n_bad     = r_bad;

        o_result               = '0;
        o_result.byte_out      = b;
        o_result.byte_role     = ROLE_IGNORED;

        case (r_phase)
            PH_PAYLOAD: begin
                o_result.byte_role = ROLE_PAYLOAD;
            end
            PH_HEADER: begin
                if (r_pos < POS_ATYP) begin
                    o_result.byte_role = (r_pos == POS_CODE && !udp) ? ROLE_CODE : ROLE_FIXED;
                    if (udp) begin
                        if (r_pos == POS_FRAG && b != 8'd0) begin
                            n_bad = 1'b1;
                        end
                    end else begin
                        if (r_pos == POS_VERSION && b != SOCKS_VERSION) begin
                            n_bad = 1'b1;
                        end
                        if (r_pos == POS_CODE) begin
                            n_code = b;
                        end
                    end
                    n_pos = r_pos + 9'd1;
                end else if (r_pos == POS_ATYP) begin
                    o_result.byte_role = ROLE_ATYP;
                    n_atyp = b;
                    if (b == ATYP_IPV4) begin
                        n_alen = LEN_IPV4;
                    end else if (b == ATYP_IPV6) begin
                        n_alen = LEN_IPV6;
                    end else begin
                        n_alen = 8'd0;
                    end
                    if (r_bad || (b != ATYP_IPV4 && b != ATYP_IPV6 && b != ATYP_DOMAIN)) begin
                        o_result.verdict = V_MALFORMED;
                        n_phase = PH_BAD;
                    end else begin
                        n_pos = POS_DLEN;
                    end
                end else if (r_atyp == ATYP_DOMAIN && r_pos == POS_DLEN) begin
                    o_result.byte_role = ROLE_DLEN;
                    n_alen = b;
                    n_pos = r_pos + 9'd1;
                end else begin
                    if (rel < alen_ext) begin
                        o_result.byte_role = ROLE_ADDR;
                        o_result.address_index = rel[7:0];
                    end else if (rel == alen_ext) begin
                        o_result.byte_role = ROLE_PORT_HI;
                        n_port_hi = b;
                    end else begin
                        o_result.byte_role = ROLE_PORT_LO;
                        o_result.port = {r_port_hi, b};
                        o_result.verdict = V_COMPLETE;
                        o_result.header_length = r_pos + 9'd1;
                        n_phase = PH_PAYLOAD;
                    end
                    n_pos = r_pos + 9'd1;
                end
            end
            default: begin
                o_result.byte_role = ROLE_IGNORED;
            end
        endcase

        // buffer ended before the header did
        if (eob && r_phase == PH_HEADER && o_result.verdict == V_PROGRESS) begin
            o_result.verdict = udp ? V_MALFORMED : V_INCOMPLETE;
        end

        o_result.address_type   = n_atyp;
        o_result.address_length = n_alen;
        o_result.code           = udp ? 8'd0 : n_code;

        // last byte of a buffer restarts the parser
        if (eob) begin
            n_pos     = '0;
            n_atyp    = '0;
            n_alen    = '0;
            n_code    = '0;
            n_port_hi = '0;
            n_phase   = PH_HEADER;
            n_bad     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_atyp    <= '0;
            r_alen    <= '0;
            r_code    <= '0;
            r_port_hi <= '0;
            r_phase   <= PH_HEADER;
            r_bad     <= 1'b0;
        end else if (i_step) begin
            r_pos     <= n_pos;
            r_atyp    <= n_atyp;
            r_alen    <= n_alen;
            r_code    <= n_code;
            r_port_hi <= n_port_hi;
            r_phase   <= n_phase;
            r_bad     <= n_bad;
        end
    end

    `ASSERT_ALWAYS(a_pos_bound, i_clk, i_rst_n, r_pos <= POS_MAX)
    `ASSERT_NEXT(a_complete_to_payload, i_clk, i_rst_n,
        i_step && o_result.verdict == V_COMPLETE && !eob, r_phase == PH_PAYLOAD)
    `ASSERT_IMPL(a_malformed_where, i_clk, i_rst_n,
        i_step && o_result.verdict == V_MALFORMED, o_result.byte_role == ROLE_ATYP || eob)

endmodule
